// ===== rtl/rv32sc_pkg.sv =====
`timescale 1ns / 1ps

package rv32sc_pkg;

	localparam int XLEN  = 32;
	localparam int IDX_W = 5;

	typedef logic [XLEN-1:0]  word_t;
	typedef logic [IDX_W-1:0] reg_idx_t;

	// fault reported with each transaction
	typedef enum logic [1:0] {
		FAULT_NONE       = 2'd0,
		FAULT_ILLEGAL_OP = 2'd1,
		FAULT_BAD_FUNCT  = 2'd2
	} fault_t;

	// major opcodes
	localparam logic [6:0] OPC_LOAD     = 7'h03;
	localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
	localparam logic [6:0] OPC_OP_IMM   = 7'h13;
	localparam logic [6:0] OPC_AUIPC    = 7'h17;
	localparam logic [6:0] OPC_STORE    = 7'h23;
	localparam logic [6:0] OPC_OP       = 7'h33;
	localparam logic [6:0] OPC_LUI      = 7'h37;
	localparam logic [6:0] OPC_BRANCH   = 7'h63;
	localparam logic [6:0] OPC_JALR     = 7'h67;
	localparam logic [6:0] OPC_JAL      = 7'h6F;
	localparam logic [6:0] OPC_SYSTEM   = 7'h73;

	// function codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SW   = 3'd2;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [6:0] F7_BASE = 7'd0;

	localparam word_t INSTR_BYTES = 32'd4;

	// everything one instruction produces
	typedef struct packed {
		word_t    next_addr;
		logic     wen;
		reg_idx_t rd;
		word_t    wval;
		logic     st;
		word_t    saddr;
		word_t    sdata;
		logic     halt;
		fault_t   fault;
	} exec_res_t;

endpackage

// ===== rtl/rv32sc_exec.sv =====
`timescale 1ns / 1ps

module rv32sc_exec
	import rv32sc_pkg::*;
#(
	parameter int REG_COUNT = 32
) (
	input  word_t     instr,
	input  word_t     pc,
	input  word_t     op_a,
	input  word_t     op_b,
	input  logic      halted_in,
	output exec_res_t res
);

	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	reg_idx_t   rd;
	word_t      imm_i;
	word_t      imm_s;
	word_t      imm_b;
	word_t      imm_j;
	word_t      imm_u;
	logic       wen;
	word_t      wval;
	logic       rd_ok;

	assign opc = instr[6:0];
	assign rd  = instr[11:7];
	assign f3  = instr[14:12];
	assign f7  = instr[31:25];

	assign imm_i = {{20{instr[31]}}, instr[31:20]};
	assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
	assign imm_u = {instr[31:12], 12'd0};

	// x0 and registers past the file discard the write
	assign rd_ok = (rd != '0) && (int'(rd) < REG_COUNT);

	always_comb begin
		wen           = 1'b0;
		wval          = '0;
		res           = '0;
		res.next_addr = pc;
		res.halt      = halted_in;
		res.fault     = FAULT_NONE;
		if (!halted_in && instr == '0) begin
			res.halt = 1'b1;
		end else if (!halted_in) begin
			res.next_addr = pc + INSTR_BYTES;
			case (opc)
				OPC_OP: begin
					if (f7 == F7_BASE && f3 == F3_ADD) begin
						wen  = 1'b1;
						wval = op_a + op_b;
					end else if (f7 == F7_BASE && f3 == F3_SLT) begin
						wen  = 1'b1;
						wval = {31'd0, $signed(op_a) < $signed(op_b)};
					end else begin
						res.fault = FAULT_BAD_FUNCT;
					end
				end
				OPC_OP_IMM: begin
					if (f3 == F3_ADD) begin
						wen  = 1'b1;
						wval = op_a + imm_i;
					end else if (f3 == F3_SLL) begin
						wen  = 1'b1;
						wval = op_a << instr[24:20];
					end else begin
						res.fault = FAULT_BAD_FUNCT;
					end
				end
				OPC_STORE: begin
					if (f3 == F3_SW) begin
						res.st    = 1'b1;
						res.saddr = op_a + imm_s;
						res.sdata = op_b;
					end else begin
						res.fault = FAULT_BAD_FUNCT;
					end
				end
				OPC_BRANCH: begin
					if (f3 == F3_BNE) begin
						if (op_a != op_b) begin
							res.next_addr = pc + imm_b;
						end
					end else begin
						res.fault = FAULT_BAD_FUNCT;
					end
				end
				OPC_AUIPC: begin
					wen  = 1'b1;
					wval = pc + imm_u;
				end
				OPC_JAL: begin
					wen           = 1'b1;
					wval          = pc + INSTR_BYTES;
					res.next_addr = pc + imm_j;
				end
				OPC_LOAD, OPC_MISC_MEM, OPC_JALR, OPC_SYSTEM, OPC_LUI: begin
					res.fault = FAULT_BAD_FUNCT;
				end
				default: begin
					res.fault     = FAULT_ILLEGAL_OP;
					res.next_addr = pc;
				end
			endcase
		end
		if (wen && rd_ok) begin
			res.wen  = 1'b1;
			res.rd   = rd;
			res.wval = wval;
		end
	end

endmodule

// ===== rtl/rv32_subset_single_cycle_core_top.sv =====
`timescale 1ns / 1ps

// Executes one RV32 instruction word per transaction: ADD, SLT, ADDI, SLLI, SW,
// BNE, AUIPC and JAL, against an internal program counter and register file.
// Each instruction transaction yields exactly one result transaction carrying
// the handled PC, the next PC, the register write, any word store, the halt
// flag and a fault code (illegal opcode, or unsupported funct which still
// advances the PC by 4). An all-zero word halts the core; afterwards every
// word is consumed and changes nothing. Throughput is one instruction per
// clock while the result side does not stall; the result transaction passes
// through the instruction register and then the result register around a
// single execute stage. The register file is read as the word is accepted and
// written as the result is loaded, with a forward path for back-to-back
// dependences. Reset clears per-register valid bits at once, so there is no
// clearing pass and the core is usable as soon as reset is released.
// Fetch and data memory live outside; the store request is only reported.
module rv32_subset_single_cycle_core_top
	import rv32sc_pkg::*;
#(
	parameter int REG_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_stall,
	input  logic [31:0] instruction_word,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] instr_address,
	output logic [31:0] next_address,
	output logic        reg_write_enable,
	output logic [4:0]  reg_write_index,
	output logic [31:0] reg_write_value,
	output logic        store_valid,
	output logic [31:0] store_address,
	output logic [31:0] store_data,
	output logic        halted,
	output logic [1:0]  fault_code
);

	localparam int RF_AW = $clog2(REG_COUNT);

	// architectural state
	word_t                pc_q;
	logic                 halt_q;
	word_t                rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;

	// instruction register
	logic     valid_s1;
	word_t    instr_s1;
	word_t    rf_a_s1;
	word_t    rf_b_s1;
	logic     live_a_s1;
	logic     live_b_s1;
	logic     byp_a_s1;
	logic     byp_b_s1;
	word_t    wb_val_s1;

	// result register
	logic      result_valid_q;
	word_t     res_pc_q;
	exec_res_t res_q;

	logic      accept;
	logic      advance;
	reg_idx_t  rs1_in;
	reg_idx_t  rs2_in;
	logic      live_a;
	logic      live_b;
	word_t     op_a;
	word_t     op_b;
	exec_res_t res;

	assign rs1_in = instruction_word[19:15];
	assign rs2_in = instruction_word[24:20];

	// advance the execute stage when the result register is free or being emptied
	assign advance     = valid_s1 && (!result_valid_q || !result_stall);
	assign instr_stall = valid_s1 && !advance;
	assign accept      = instr_valid && !instr_stall;

	// sources that read a written register; x0, out-of-range and unwritten read zero
	assign live_a = (rs1_in != '0) && (int'(rs1_in) < REG_COUNT) && rf_vld_q[rs1_in[RF_AW-1:0]];
	assign live_b = (rs2_in != '0) && (int'(rs2_in) < REG_COUNT) && rf_vld_q[rs2_in[RF_AW-1:0]];

	// forward the write retiring at the edge the operands were sampled
	assign op_a = byp_a_s1 ? wb_val_s1 : (live_a_s1 ? rf_a_s1 : '0);
	assign op_b = byp_b_s1 ? wb_val_s1 : (live_b_s1 ? rf_b_s1 : '0);

	rv32sc_exec #(
		.REG_COUNT(REG_COUNT)
	) u_exec (
		.instr    (instr_s1),
		.pc       (pc_q),
		.op_a     (op_a),
		.op_b     (op_b),
		.halted_in(halt_q),
		.res      (res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			pc_q           <= '0;
			halt_q         <= 1'b0;
			rf_vld_q       <= '0;
			live_a_s1      <= 1'b0;
			live_b_s1      <= 1'b0;
			byp_a_s1       <= 1'b0;
			byp_b_s1       <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				live_a_s1 <= live_a;
				live_b_s1 <= live_b;
				byp_a_s1  <= advance && res.wen && (res.rd == rs1_in);
				byp_b_s1  <= advance && res.wen && (res.rd == rs2_in);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				pc_q           <= res.next_addr;
				halt_q         <= res.halt;
				if (res.wen) begin
					rf_vld_q[res.rd[RF_AW-1:0]] <= 1'b1;
				end
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload: instruction, operands, result
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1  <= instruction_word;
			rf_a_s1   <= rf_mem[rs1_in[RF_AW-1:0]];
			rf_b_s1   <= rf_mem[rs2_in[RF_AW-1:0]];
			wb_val_s1 <= res.wval;
		end
		if (advance) begin
			res_pc_q <= pc_q;
			res_q    <= res;
		end
	end

	// register file write port
	always_ff @(posedge clk) begin
		if (advance && res.wen) begin
			rf_mem[res.rd[RF_AW-1:0]] <= res.wval;
		end
	end

	assign result_valid     = result_valid_q;
	assign instr_address    = res_pc_q;
	assign next_address     = res_q.next_addr;
	assign reg_write_enable = res_q.wen;
	assign reg_write_index  = res_q.rd;
	assign reg_write_value  = res_q.wval;
	assign store_valid      = res_q.st;
	assign store_address    = res_q.saddr;
	assign store_data       = res_q.sdata;
	assign halted           = res_q.halt;
	assign fault_code       = res_q.fault;

endmodule

// ===== rtl/rv32sc_checker.sv =====
`timescale 1ns / 1ps

module rv32sc_checker
	import rv32sc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] instr_address,
	input logic [31:0] next_address,
	input logic        reg_write_enable,
	input logic [4:0]  reg_write_index,
	input logic        store_valid,
	input logic        halted,
	input logic [1:0]  fault_code
);

	logic  result_take;
	logic  seen_q;
	logic  halt_seen_q;
	word_t last_next_q;

	assign result_take = result_valid && !result_stall;

	// track the last delivered result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			halt_seen_q <= 1'b0;
			last_next_q <= '0;
		end else if (result_take) begin
			seen_q      <= 1'b1;
			halt_seen_q <= halted;
			last_next_q <= next_address;
		end
	end

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(instr_address)
			&& $stable(next_address))
		else $error("stalled result transaction changed");

	// each instruction continues from where the previous one left the PC
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q |-> instr_address == last_next_q)
		else $error("PC sequence broken between result transactions");

	// halt is sticky
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && halt_seen_q |-> halted && next_address == instr_address)
		else $error("core left the halted state");

	// illegal opcode changes nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fault_code == FAULT_ILLEGAL_OP |->
			!reg_write_enable && !store_valid && next_address == instr_address)
		else $error("illegal opcode had an effect");

	// x0 is never reported as written, and a reported write carries no fault
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && reg_write_enable |-> reg_write_index != '0 && fault_code == FAULT_NONE)
		else $error("bad register write reported");

endmodule

bind rv32_subset_single_cycle_core_top rv32sc_checker u_rv32sc_checker (.*);
